/* rtl/owbm_pkg.sv */
package owbm_pkg;

	// Register file geometry
	localparam int unsigned NumRegs = 8;
	localparam int unsigned RegW    = 10;
	localparam int unsigned IdxW    = 3;

	typedef logic [RegW-1:0] reg_t;
	typedef logic [1:0]      op_t;
	typedef logic [3:0]      phase_t;

	// Operation codes
	localparam op_t OpTick  = 2'd0;
	localparam op_t OpReset = 2'd1;
	localparam op_t OpWrite = 2'd2;
	localparam op_t OpRead  = 2'd3;

	// Phase codes; each active phase times out on the register at (phase - 1)
	localparam phase_t PhIdle   = 4'd0;
	localparam phase_t PhRstLow = 4'd1;
	localparam phase_t PhRstWt  = 4'd2;
	localparam phase_t PhRstRec = 4'd3;
	localparam phase_t PhWrLow  = 4'd4;
	localparam phase_t PhWrHold = 4'd5;
	localparam phase_t PhRdLow  = 4'd6;
	localparam phase_t PhRdWt   = 4'd7;
	localparam phase_t PhRdRec  = 4'd8;

	// Register defaults in microsecond ticks
	localparam reg_t RegDefaults [NumRegs] = '{
		10'd500, 10'd70, 10'd500, 10'd10, 10'd50, 10'd5, 10'd5, 10'd50
	};

endpackage

/* rtl/one_wire_bus_master.sv */
// 1-Wire bus master for reset with presence detect, byte write and byte read,
// least significant bit first. Each accepted item is one microsecond tick with
// the sampled line level; while idle it may also start a command. One result
// per item, one item per clock: the sequencer state is updated and the result
// registered at the same edge, so a result appears in the cycle after its item
// and the input stalls only while a registered result waits on out_stall.
// Slot timing comes from eight tick-count registers, which the user must write
// on the cfg port only while idle; the block does not enforce it. Only their
// low COUNT_BITS bits are compared with the tick counter; zero acts as one tick.
module one_wire_bus_master #(
	parameter int unsigned COUNT_BITS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_write,
	input  logic [owbm_pkg::IdxW-1:0] cfg_index,
	input  logic [owbm_pkg::RegW-1:0] cfg_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [7:0]                write_byte,
	input  logic                      line_level,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      drive_low,
	output logic                      busy_res,
	output logic                      done_res,
	output logic                      presence_level,
	output logic [7:0]                read_result,
	output logic                      rejected
);

	localparam int unsigned WideW = (COUNT_BITS > owbm_pkg::RegW) ?
		COUNT_BITS : owbm_pkg::RegW;

	owbm_pkg::reg_t          regs_q [owbm_pkg::NumRegs];
	owbm_pkg::phase_t        phase_q;
	logic [COUNT_BITS-1:0]   tick_q;
	logic [2:0]              bit_q;
	logic [7:0]              shift_q;
	logic                    presence_q;
	logic [7:0]              read_byte_q;
	logic                    out_valid_q;
	logic                    drive_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    rejected_q;

	logic                    accept;
	owbm_pkg::phase_t        ph;
	logic [2:0]              bi;
	logic [7:0]              sh;
	logic                    rej;
	logic                    drive;
	logic                    done;
	owbm_pkg::phase_t        ph_n;
	logic [COUNT_BITS-1:0]   tick_n;
	logic [2:0]              bit_n;
	logic [7:0]              shift_n;
	logic                    presence_n;
	logic [7:0]              read_byte_n;
	logic [owbm_pkg::IdxW-1:0] reg_sel;
	logic [WideW-1:0]        limit_wide;
	logic [COUNT_BITS-1:0]   limit;
	logic [COUNT_BITS-1:0]   tick_inc;
	logic [2:0]              bit_inc;

	// Hold the input while a registered result waits
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Timeout register of the current phase, cut or widened to the counter
	assign reg_sel    = owbm_pkg::IdxW'(ph - 4'd1);
	assign limit_wide = WideW'(regs_q[reg_sel]);
	assign limit      = limit_wide[COUNT_BITS-1:0];
	assign tick_inc   = tick_q + COUNT_BITS'(1);
	assign bit_inc    = bi + 3'd1;

	// Start a command when idle, then advance the current phase by one tick
	always_comb begin
		ph          = phase_q;
		bi          = bit_q;
		sh          = shift_q;
		rej         = 1'b0;
		drive       = 1'b0;
		done        = 1'b0;
		tick_n      = tick_q;
		presence_n  = presence_q;
		read_byte_n = read_byte_q;

		if (phase_q == owbm_pkg::PhIdle) begin
			bi     = 3'd0;
			tick_n = '0;
			case (operation)
				owbm_pkg::OpReset: ph = owbm_pkg::PhRstLow;
				owbm_pkg::OpWrite: begin
					sh = write_byte;
					ph = owbm_pkg::PhWrLow;
				end
				owbm_pkg::OpRead: begin
					sh = 8'h00;
					ph = owbm_pkg::PhRdLow;
				end
				default: ;
			endcase
		end else if (operation != owbm_pkg::OpTick) begin
			rej = 1'b1;
		end

		ph_n    = ph;
		bit_n   = bi;
		shift_n = sh;

		unique case (ph) inside
			owbm_pkg::PhRstLow, owbm_pkg::PhRstWt, owbm_pkg::PhRstRec,
			owbm_pkg::PhWrLow, owbm_pkg::PhWrHold, owbm_pkg::PhRdLow,
			owbm_pkg::PhRdWt, owbm_pkg::PhRdRec: begin
				// Line drive for this tick
				if (ph == owbm_pkg::PhRstLow || ph == owbm_pkg::PhWrLow ||
				    ph == owbm_pkg::PhRdLow) begin
					drive = 1'b1;
				end else if (ph == owbm_pkg::PhWrHold) begin
					drive = !sh[bi];
				end

				if (tick_inc < limit) begin
					tick_n = tick_inc;
				end else begin
					tick_n = '0;
					unique case (ph)
						owbm_pkg::PhRstLow: ph_n = owbm_pkg::PhRstWt;
						owbm_pkg::PhRstWt: begin
							presence_n = line_level;
							ph_n       = owbm_pkg::PhRstRec;
						end
						owbm_pkg::PhRstRec: begin
							ph_n = owbm_pkg::PhIdle;
							done = 1'b1;
						end
						owbm_pkg::PhWrLow: ph_n = owbm_pkg::PhWrHold;
						owbm_pkg::PhWrHold: begin
							bit_n = bit_inc;
							if (bit_inc == 3'd0) begin
								ph_n = owbm_pkg::PhIdle;
								done = 1'b1;
							end else begin
								ph_n = owbm_pkg::PhWrLow;
							end
						end
						owbm_pkg::PhRdLow: ph_n = owbm_pkg::PhRdWt;
						owbm_pkg::PhRdWt: begin
							shift_n[bi] = sh[bi] | line_level;
							ph_n        = owbm_pkg::PhRdRec;
						end
						default: begin
							bit_n = bit_inc;
							if (bit_inc == 3'd0) begin
								read_byte_n = sh;
								ph_n        = owbm_pkg::PhIdle;
								done        = 1'b1;
							end else begin
								ph_n = owbm_pkg::PhRdLow;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// Write the timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < owbm_pkg::NumRegs; i++) begin
				regs_q[i] <= owbm_pkg::RegDefaults[i];
			end
		end else if (cfg_write) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// Advance the sequencer on each transfer in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= owbm_pkg::PhIdle;
			tick_q      <= '0;
			bit_q       <= 3'd0;
			shift_q     <= 8'h00;
			presence_q  <= 1'b1;
			read_byte_q <= 8'h00;
		end else if (accept) begin
			phase_q     <= ph_n;
			tick_q      <= tick_n;
			bit_q       <= bit_n;
			shift_q     <= shift_n;
			presence_q  <= presence_n;
			read_byte_q <= read_byte_n;
		end
	end

	// Result valid: set on a transfer in, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Register the per-tick flags
	always_ff @(posedge clk) begin
		if (accept) begin
			drive_q    <= drive;
			busy_q     <= (ph_n != owbm_pkg::PhIdle);
			done_q     <= done;
			rejected_q <= rej;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_low      = drive_q;
	assign busy_res       = busy_q;
	assign done_res       = done_q;
	assign rejected       = rejected_q;
	// Status registers change only on a transfer in, so they serve as outputs
	assign presence_level = presence_q;
	assign read_result    = read_byte_q;

endmodule
